FILE: rtl/vrbs_pkg.sv
`timescale 1ns / 1ps

package vrbs_pkg;

  localparam int STACK_BYTES_DEF  = 1024;
  localparam int HEADER_BYTES_DEF = 4;
  localparam int MAX_COPY_DEF     = 64;

  localparam int OP_W   = 3;
  localparam int LEN_W  = 11;
  localparam int BYTE_W = 8;
  localparam int STS_W  = 2;

  typedef enum logic [OP_W-1:0] {
    OP_PUSH_START  = 3'd0,
    OP_PUSH_BYTE   = 3'd1,
    OP_POP         = 3'd2,
    OP_PEEK        = 3'd3,
    OP_CLEAR       = 3'd4,
    OP_CHECK_FULL  = 3'd5,
    OP_CHECK_EMPTY = 3'd6
  } op_t;

  typedef enum logic [STS_W-1:0] {
    STS_OK      = 2'd0,
    STS_FULL    = 2'd1,
    STS_EMPTY   = 2'd2,
    STS_REFUSED = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_HDR_WR,
    ST_HDR_HI,
    ST_SIZE,
    ST_COPY_RD,
    ST_EMIT,
    ST_ZERO
  } state_t;

  typedef struct packed {
    logic    take;
    logic    mark_pop;
    logic    push_start;
    logic    push_byte;
    logic    clear;
    logic    hdr_wr;
    logic    rd_hdr0;
    logic    rd_hdr1;
    logic    size_set;
    logic    copy_rd;
    logic    pop_commit;
    logic    res_load;
    logic    res_data;
    logic    res_last;
    status_t res_status;
  } cmd_t;

  typedef struct packed {
    logic push_open;
    logic empty;
    logic too_big;
    logic hdr_done;
    logic n_zero;
    logic copy_last;
    logic out_free;
  } stat_t;

endpackage

FILE: rtl/vrbs_if.sv
`timescale 1ns / 1ps

interface vrbs_in_if;
  import vrbs_pkg::*;

  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   opcode;
  logic [LEN_W-1:0]  length;
  logic [BYTE_W-1:0] data_byte;

  modport source (output valid, output opcode, output length, output data_byte,
                  input ready);
  modport sink (input valid, input opcode, input length, input data_byte,
                output ready);
endinterface

interface vrbs_out_if;
  import vrbs_pkg::*;

  logic              valid;
  logic              ready;
  logic [STS_W-1:0]  status;
  logic              data_valid;
  logic [BYTE_W-1:0] data_out;
  logic              last;

  modport source (output valid, output status, output data_valid, output data_out,
                  output last, input ready);
  modport sink (input valid, input status, input data_valid, input data_out,
                input last, output ready);
endinterface

FILE: rtl/variable_record_byte_stack.sv
`timescale 1ns / 1ps

// Stack of variable-length byte records in a single-port-write, single-port-read
// byte memory that fills downward from the top; each record carries a
// HEADER_BYTES little-endian length below its payload. Clear, the full and empty
// checks, push byte and every refused or failing item are handled in the idle
// state alone. Push start then writes the header one byte per cycle through the
// memory write port. Pop and peek read two header bytes through the registered
// read port, size the copy, then emit one payload byte per cycle while the
// result side keeps taking; with nothing to copy, one result with no data.
// A result still waiting in the output register holds off the next item until
// the result side takes it, so an item may take longer while the result side
// stalls. No clearing pass after reset.
module variable_record_byte_stack #(
  parameter int STACK_BYTES  = vrbs_pkg::STACK_BYTES_DEF,
  parameter int HEADER_BYTES = vrbs_pkg::HEADER_BYTES_DEF,
  parameter int MAX_COPY     = vrbs_pkg::MAX_COPY_DEF
) (
  input logic        clk,
  input logic        rst_n,
  vrbs_in_if.sink    in_ch,
  vrbs_out_if.source out_ch
);
  import vrbs_pkg::*;

  cmd_t  cmd;
  stat_t st;

  vrbs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_opcode (in_ch.opcode),
    .in_ready  (in_ch.ready),
    .st        (st),
    .cmd       (cmd)
  );

  vrbs_dpath #(
    .STACK_BYTES  (STACK_BYTES),
    .HEADER_BYTES (HEADER_BYTES),
    .MAX_COPY     (MAX_COPY)
  ) u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_length      (in_ch.length),
    .in_data_byte   (in_ch.data_byte),
    .cmd            (cmd),
    .st             (st),
    .out_ready      (out_ch.ready),
    .out_valid      (out_ch.valid),
    .out_status     (out_ch.status),
    .out_data_valid (out_ch.data_valid),
    .out_data_out   (out_ch.data_out),
    .out_last       (out_ch.last)
  );

  // a new result never overwrites one still waiting
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.res_load |-> st.out_free)
    else $error("result loaded while previous result still pending");

  // one memory write per cycle
  a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.push_byte && cmd.hdr_wr))
    else $error("push byte and header write collide");

  // record is released only with the final result of the pop
  a_commit_last: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.pop_commit |-> (cmd.res_load && cmd.res_last))
    else $error("pop released without final result");

  // input is held off once a pop or peek starts reading its header
  a_copy_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.rd_hdr0 && in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("input taken during pop or peek");

endmodule

FILE: rtl/vrbs_ctrl.sv
`timescale 1ns / 1ps

module vrbs_ctrl (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    in_valid,
  input  logic [vrbs_pkg::OP_W-1:0] in_opcode,
  output logic                    in_ready,
  input  vrbs_pkg::stat_t         st,
  output vrbs_pkg::cmd_t          cmd
);
  import vrbs_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_ready  = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = st.out_free;
        if (in_valid && st.out_free) begin
          cmd.take       = 1'b1;
          cmd.res_load   = 1'b1;
          cmd.res_last   = 1'b1;
          cmd.res_status = STS_OK;
          if (in_opcode == OP_PUSH_BYTE) begin
            if (st.push_open) begin
              cmd.push_byte = 1'b1;
            end else begin
              cmd.res_status = STS_REFUSED;
            end
          end else if (st.push_open) begin
            cmd.res_status = STS_REFUSED;
          end else begin
            unique case (in_opcode)
              OP_PUSH_START: begin
                if (st.too_big) begin
                  cmd.res_status = STS_FULL;
                end else begin
                  cmd.push_start = 1'b1;
                  state_nxt      = ST_HDR_WR;
                end
              end
              OP_POP, OP_PEEK: begin
                if (st.empty) begin
                  cmd.res_status = STS_EMPTY;
                end else begin
                  cmd.res_load = 1'b0;
                  cmd.res_last = 1'b0;
                  cmd.rd_hdr0  = 1'b1;
                  cmd.mark_pop = (in_opcode == OP_POP);
                  state_nxt    = ST_HDR_HI;
                end
              end
              OP_CLEAR: begin
                cmd.clear = 1'b1;
              end
              OP_CHECK_FULL: begin
                cmd.res_status = st.too_big ? STS_FULL : STS_OK;
              end
              OP_CHECK_EMPTY: begin
                cmd.res_status = st.empty ? STS_EMPTY : STS_OK;
              end
              default: begin
                cmd.res_status = STS_REFUSED;
              end
            endcase
          end
        end
      end
      ST_HDR_WR: begin
        cmd.hdr_wr = 1'b1;
        if (st.hdr_done) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_HDR_HI: begin
        cmd.rd_hdr1 = 1'b1;
        state_nxt   = ST_SIZE;
      end
      ST_SIZE: begin
        cmd.size_set = 1'b1;
        state_nxt    = st.n_zero ? ST_ZERO : ST_COPY_RD;
      end
      ST_COPY_RD: begin
        cmd.copy_rd = 1'b1;
        state_nxt   = ST_EMIT;
      end
      ST_EMIT: begin
        if (st.out_free) begin
          cmd.res_load   = 1'b1;
          cmd.res_data   = 1'b1;
          cmd.res_last   = st.copy_last;
          cmd.res_status = STS_OK;
          if (st.copy_last) begin
            cmd.pop_commit = 1'b1;
            state_nxt      = ST_IDLE;
          end else begin
            cmd.copy_rd = 1'b1;
          end
        end
      end
      ST_ZERO: begin
        if (st.out_free) begin
          cmd.res_load   = 1'b1;
          cmd.res_last   = 1'b1;
          cmd.res_status = STS_OK;
          cmd.pop_commit = 1'b1;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/vrbs_dpath.sv
`timescale 1ns / 1ps

module vrbs_dpath #(
  parameter int STACK_BYTES  = vrbs_pkg::STACK_BYTES_DEF,
  parameter int HEADER_BYTES = vrbs_pkg::HEADER_BYTES_DEF,
  parameter int MAX_COPY     = vrbs_pkg::MAX_COPY_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [vrbs_pkg::LEN_W-1:0]  in_length,
  input  logic [vrbs_pkg::BYTE_W-1:0] in_data_byte,
  input  vrbs_pkg::cmd_t              cmd,
  output vrbs_pkg::stat_t             st,
  input  logic                        out_ready,
  output logic                        out_valid,
  output logic [vrbs_pkg::STS_W-1:0]  out_status,
  output logic                        out_data_valid,
  output logic [vrbs_pkg::BYTE_W-1:0] out_data_out,
  output logic                        out_last
);
  import vrbs_pkg::*;

  localparam int AW   = $clog2(STACK_BYTES);
  localparam int TW   = $clog2(STACK_BYTES + 1);
  localparam int CW   = ((TW > LEN_W) ? TW : LEN_W) + 1;
  localparam int HCW  = $clog2(HEADER_BYTES);
  localparam int CNTW = $clog2(MAX_COPY + 1);

  localparam logic [CW-1:0]    STACK_C = CW'(STACK_BYTES);
  localparam logic [CW-1:0]    HDR_C   = CW'(HEADER_BYTES);
  localparam logic [HCW-1:0]   HLAST_C = HCW'(HEADER_BYTES - 1);
  localparam logic [LEN_W-1:0] MAXC_C  = LEN_W'(MAX_COPY);
  localparam logic [TW-1:0]    TOP_RST = TW'(STACK_BYTES);

  logic [BYTE_W-1:0] mem [STACK_BYTES];

  logic [TW-1:0]     top_r;
  logic [LEN_W-1:0]  rem_r;
  logic [AW-1:0]     paddr_r;
  logic [HCW-1:0]    hcnt_r;
  logic [LEN_W-1:0]  len_r;
  logic              pop_r;
  logic [BYTE_W-1:0] rdata_r;
  logic [BYTE_W-1:0] lo_r;
  logic [LEN_W-1:0]  stored_r;
  logic [CNTW-1:0]   left_r;
  logic [AW-1:0]     cp_addr_r;

  logic              out_valid_r;
  logic [STS_W-1:0]  out_status_r;
  logic              out_dv_r;
  logic [BYTE_W-1:0] out_data_r;
  logic              out_last_r;

  logic [CW-1:0]     top_ext;
  logic [CW-1:0]     len_ext;
  logic [CW-1:0]     pop_sum;
  logic [LEN_W-1:0]  stored;
  logic [LEN_W-1:0]  lim;
  logic [LEN_W-1:0]  ncopy;
  logic [BYTE_W-1:0] hbyte;
  logic              we;
  logic [AW-1:0]     waddr;
  logic [BYTE_W-1:0] wdata;
  logic              re;
  logic [AW-1:0]     raddr;

  assign top_ext = CW'(top_r);
  assign len_ext = CW'(in_length);
  assign pop_sum = top_ext + HDR_C + CW'(stored_r);

  // header length as read back, low byte first
  assign stored = {rdata_r[LEN_W-BYTE_W-1:0], lo_r};
  assign lim    = (len_r > MAXC_C) ? MAXC_C : len_r;
  assign ncopy  = (lim > stored) ? stored : lim;

  always_comb begin
    hbyte = '0;
    if (hcnt_r == HCW'(0)) begin
      hbyte = len_r[BYTE_W-1:0];
    end else if (hcnt_r == HCW'(1)) begin
      hbyte = BYTE_W'(len_r[LEN_W-1:BYTE_W]);
    end
  end

  assign we    = cmd.push_byte || cmd.hdr_wr;
  assign waddr = cmd.push_byte ? paddr_r : (AW'(top_r) + AW'(hcnt_r));
  assign wdata = cmd.push_byte ? in_data_byte : hbyte;

  assign re = cmd.rd_hdr0 || cmd.rd_hdr1 || cmd.copy_rd;
  always_comb begin
    raddr = cp_addr_r;
    if (cmd.rd_hdr0) begin
      raddr = AW'(top_r);
    end else if (cmd.rd_hdr1) begin
      raddr = AW'(top_r) + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  // stack pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      top_r   <= TOP_RST;
      rem_r   <= '0;
      paddr_r <= '0;
    end else begin
      if (cmd.push_start) begin
        top_r   <= TW'(top_ext - len_ext - HDR_C);
        paddr_r <= AW'(top_ext - len_ext);
        rem_r   <= in_length;
      end else if (cmd.push_byte) begin
        paddr_r <= paddr_r + AW'(1);
        rem_r   <= rem_r - LEN_W'(1);
      end else if (cmd.clear) begin
        top_r <= TOP_RST;
      end else if (cmd.pop_commit && pop_r) begin
        top_r <= (pop_sum > STACK_C) ? TOP_RST : TW'(pop_sum);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take) begin
      len_r <= in_length;
      pop_r <= cmd.mark_pop;
    end
    if (cmd.push_start) begin
      hcnt_r <= '0;
    end else if (cmd.hdr_wr) begin
      hcnt_r <= hcnt_r + HCW'(1);
    end
    if (cmd.rd_hdr1) begin
      lo_r <= rdata_r;
    end
    if (cmd.size_set) begin
      stored_r  <= stored;
      left_r    <= CNTW'(ncopy);
      cp_addr_r <= AW'(top_ext + HDR_C);
    end else begin
      if (cmd.copy_rd) begin
        cp_addr_r <= cp_addr_r + AW'(1);
      end
      if (cmd.res_load && cmd.res_data) begin
        left_r <= left_r - CNTW'(1);
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.res_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.res_load) begin
      out_status_r <= cmd.res_status;
      out_dv_r     <= cmd.res_data;
      out_data_r   <= cmd.res_data ? rdata_r : '0;
      out_last_r   <= cmd.res_last;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_data_valid = out_dv_r;
  assign out_data_out   = out_data_r;
  assign out_last       = out_last_r;

  assign st.push_open = (rem_r != '0);
  assign st.empty     = (top_ext >= STACK_C);
  assign st.too_big   = ((len_ext + HDR_C) > top_ext);
  assign st.hdr_done  = (hcnt_r == HLAST_C);
  assign st.n_zero    = (ncopy == '0);
  assign st.copy_last = (left_r == CNTW'(1));
  assign st.out_free  = !out_valid_r || out_ready;

endmodule

FILE: test/tb.sv
`timescale 1ns / 1ps

module tb;
  import vrbs_pkg::*;

  localparam int DEPTH    = STACK_BYTES_DEF;
  localparam int HDR      = HEADER_BYTES_DEF;
  localparam int COPY_MAX = MAX_COPY_DEF;
  localparam logic [OP_W-1:0] OP_UNUSED = 3'd7;
  localparam int RANDOM_ITEMS = 130;
  localparam int HOLD_CYCLES  = 200;

  typedef struct packed {
    logic [STS_W-1:0]  status;
    logic              data_valid;
    logic [BYTE_W-1:0] data_out;
    logic              last;
  } stack_res_t;

  class byte_stack_scoreboard;
    logic [7:0] store [DEPTH];
    int unsigned top_ptr;
    int unsigned push_left;
    int unsigned push_addr;
    stack_res_t awaited[$];
    int errors;

    function new();
      top_ptr = DEPTH;
      push_left = 0;
      push_addr = 0;
      errors = 0;
      foreach (store[i]) store[i] = 8'h00;
    endfunction

    function void queue_result(logic [STS_W-1:0] status, logic dv, logic [7:0] data,
                               logic last);
      stack_res_t r;
      r.status = status;
      r.data_valid = dv;
      r.data_out = data;
      r.last = last;
      awaited.push_back(r);
    endfunction

    function void copy_out(int unsigned limit, bit do_pop);
      int unsigned stored;
      int unsigned n;
      stored = 0;
      if (top_ptr >= DEPTH) begin
        queue_result(STS_EMPTY, 1'b0, 8'h00, 1'b1);
        return;
      end
      for (int i = 0; i < HDR; i++) stored |= int'(store[top_ptr + i]) << (8 * i);
      if (stored > DEPTH) stored = DEPTH;
      n = (limit > COPY_MAX) ? COPY_MAX : limit;
      if (n > stored) n = stored;
      if (n == 0) begin
        queue_result(STS_OK, 1'b0, 8'h00, 1'b1);
      end else begin
        for (int i = 0; i < n; i++)
          queue_result(STS_OK, 1'b1, store[top_ptr + HDR + i], (i + 1) == n);
      end
      if (do_pop)
        top_ptr = (top_ptr + HDR + stored > DEPTH) ? DEPTH : top_ptr + HDR + stored;
    endfunction

    function void note_input(logic [OP_W-1:0] op, logic [LEN_W-1:0] len, logic [7:0] b);
      int unsigned need;
      need = int'(len) + HDR;
      if (op == OP_PUSH_BYTE) begin
        if (push_left == 0) begin
          queue_result(STS_REFUSED, 1'b0, 8'h00, 1'b1);
        end else begin
          store[push_addr] = b;
          push_addr++;
          push_left--;
          queue_result(STS_OK, 1'b0, 8'h00, 1'b1);
        end
        return;
      end
      if (push_left != 0 || op == OP_UNUSED) begin
        queue_result(STS_REFUSED, 1'b0, 8'h00, 1'b1);
        return;
      end
      case (op)
        OP_PUSH_START: begin
          if (need > top_ptr) begin
            queue_result(STS_FULL, 1'b0, 8'h00, 1'b1);
          end else begin
            top_ptr -= len;
            push_addr = top_ptr;
            top_ptr -= HDR;
            for (int i = 0; i < HDR; i++) store[top_ptr + i] = 8'((32'(len) >> (8 * i)));
            push_left = len;
            queue_result(STS_OK, 1'b0, 8'h00, 1'b1);
          end
        end
        OP_POP: copy_out(len, 1'b1);
        OP_PEEK: copy_out(len, 1'b0);
        OP_CLEAR: begin
          top_ptr = DEPTH;
          queue_result(STS_OK, 1'b0, 8'h00, 1'b1);
        end
        OP_CHECK_FULL: queue_result((need > top_ptr) ? STS_FULL : STS_OK, 1'b0, 8'h00, 1'b1);
        default: queue_result((top_ptr >= DEPTH) ? STS_EMPTY : STS_OK, 1'b0, 8'h00, 1'b1);
      endcase
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 40) $display("error at %0t: %s", $time, msg);
    endtask

    task check_result(logic [STS_W-1:0] status, logic dv, logic [7:0] data, logic last);
      stack_res_t want;
      if (awaited.size() == 0) begin
        report($sformatf("result with none awaited: status %0d dv %0b data %02h last %0b",
                         status, dv, data, last));
        return;
      end
      want = awaited.pop_front();
      if (status !== want.status || dv !== want.data_valid || data !== want.data_out ||
          last !== want.last)
        report($sformatf("got status %0d dv %0b data %02h last %0b, want %0d %0b %02h %0b",
                         status, dv, data, last, want.status, want.data_valid,
                         want.data_out, want.last));
    endtask
  endclass

  logic clk;
  logic rst_n;
  bit calm;
  bit hold_req;
  int sent_count;
  byte_stack_scoreboard sb = new();

  vrbs_in_if in_if();
  vrbs_out_if out_if();

  variable_record_byte_stack uut (
    .clk(clk),
    .rst_n(rst_n),
    .in_ch(in_if),
    .out_ch(out_if)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    #1_000_000;
    $display("variable_record_byte_stack: mismatch");
    $finish;
  end

  always @(posedge clk) begin
    if (rst_n && out_if.valid && out_if.ready)
      sb.check_result(out_if.status, out_if.data_valid, out_if.data_out, out_if.last);
  end

  // receiver: random stalls, one long hold-off on request
  initial begin
    int stall;
    out_if.ready = 1'b0;
    @(posedge clk);
    while (!rst_n) @(posedge clk);
    forever begin
      if (hold_req) begin
        stall = HOLD_CYCLES;
        hold_req = 1'b0;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        stall = $urandom_range(1, 5);
      end else begin
        stall = 0;
      end
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      @(posedge clk);
    end
  end

  task automatic send(logic [OP_W-1:0] op, logic [LEN_W-1:0] len, logic [7:0] b);
    int gap;
    if (!calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 5);
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.opcode <= op;
    in_if.length <= len;
    in_if.data_byte <= b;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    sb.note_input(op, len, b);
    sent_count++;
  endtask

  task automatic wait_drained();
    in_if.valid <= 1'b0;
    while (sb.awaited.size() != 0) @(posedge clk);
  endtask

  function automatic logic [LEN_W-1:0] rand_len();
    return LEN_W'($urandom_range(0, 2047));
  endfunction

  function automatic logic [7:0] rand_byte();
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic logic [LEN_W-1:0] rand_limit();
    case ($urandom_range(0, 3))
      0: return LEN_W'($urandom_range(0, 3));
      1: return LEN_W'($urandom_range(0, 15));
      2: return 11'h7ff;
      default: return LEN_W'($urandom_range(0, 2047));
    endcase
  endfunction

  task automatic push_record(logic [LEN_W-1:0] len, bit broken);
    logic [OP_W-1:0] stray;
    send(OP_PUSH_START, len, rand_byte());
    while (sb.push_left > 0) begin
      if (broken && $urandom_range(0, 3) == 0) begin
        stray = OP_W'($urandom_range(0, 7));
        if (stray == OP_PUSH_BYTE) stray = OP_POP;
        send(stray, rand_len(), rand_byte());
      end
      send(OP_PUSH_BYTE, rand_len(), rand_byte());
    end
  endtask

  task automatic run_directed();
    send(OP_CHECK_EMPTY, rand_len(), rand_byte());
    send(OP_POP, 11'd5, rand_byte());
    send(OP_PEEK, 11'h7ff, rand_byte());
    send(OP_PUSH_BYTE, rand_len(), 8'hff);
    send(OP_UNUSED, rand_len(), rand_byte());
    send(OP_CHECK_FULL, 11'h7ff, rand_byte());
    send(OP_CHECK_FULL, 11'(DEPTH - HDR), rand_byte());
    send(OP_CHECK_FULL, 11'(DEPTH - HDR + 1), rand_byte());
    send(OP_PUSH_START, 11'(DEPTH - HDR + 1), rand_byte());
    // zero-length record
    send(OP_PUSH_START, 11'd0, rand_byte());
    send(OP_PEEK, 11'd9, rand_byte());
    send(OP_POP, 11'd0, rand_byte());
    send(OP_CHECK_EMPTY, rand_len(), rand_byte());
    // operations while a push is open
    send(OP_PUSH_START, 11'd3, rand_byte());
    send(OP_PUSH_START, 11'd1, rand_byte());
    send(OP_CLEAR, rand_len(), rand_byte());
    send(OP_PUSH_BYTE, 11'h7ff, 8'h00);
    send(OP_PUSH_BYTE, 11'h000, 8'hff);
    send(OP_POP, 11'h7ff, rand_byte());
    send(OP_PUSH_BYTE, rand_len(), 8'ha5);
    send(OP_CHECK_EMPTY, rand_len(), rand_byte());
    send(OP_PEEK, 11'h7ff, rand_byte());
    send(OP_PEEK, 11'd0, rand_byte());
    send(OP_POP, 11'd1, rand_byte());
    send(OP_CLEAR, rand_len(), rand_byte());
  endtask

  task automatic run_random();
    int start;
    int pick;
    bit big_done;
    bit paused;
    start = sent_count;
    big_done = 1'b0;
    paused = 1'b0;
    while (sent_count - start < RANDOM_ITEMS) begin
      if (sent_count - start > RANDOM_ITEMS - 25) calm = 1'b1;
      if (!big_done && sent_count - start > 30) begin
        // record longer than the copy limit, then hold off the receiver
        push_record(11'd66, 1'b0);
        hold_req = 1'b1;
        send(OP_PEEK, 11'h7ff, rand_byte());
        send(OP_POP, 11'($urandom_range(COPY_MAX, 100)), rand_byte());
        send(OP_CHECK_EMPTY, rand_len(), rand_byte());
        send(OP_PEEK, rand_limit(), rand_byte());
        big_done = 1'b1;
      end else if (!paused && sent_count - start > 80) begin
        wait_drained();
        paused = 1'b1;
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 45) push_record(11'($urandom_range(0, 12)), $urandom_range(0, 7) == 0);
        else if (pick < 60) send(OP_POP, rand_limit(), rand_byte());
        else if (pick < 70) send(OP_PEEK, rand_limit(), rand_byte());
        else if (pick < 78) send(OP_CHECK_FULL, rand_len(), rand_byte());
        else if (pick < 84) send(OP_CHECK_EMPTY, rand_len(), rand_byte());
        else if (pick < 88) send(OP_CLEAR, rand_len(), rand_byte());
        else if (pick < 94) send(OP_PUSH_BYTE, rand_len(), rand_byte());
        else if (pick < 97) send(OP_UNUSED, rand_len(), rand_byte());
        else send(OP_PUSH_START, 11'($urandom_range(1000, 2047)), rand_byte());
      end
    end
  endtask

  initial begin
    int waited;
    rst_n = 1'b0;
    calm = 1'b0;
    hold_req = 1'b0;
    sent_count = 0;
    in_if.valid = 1'b0;
    in_if.opcode = '0;
    in_if.length = '0;
    in_if.data_byte = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    run_directed();
    run_random();
    wait_drained();
    waited = 0;
    while (waited < 20) begin
      @(posedge clk);
      waited++;
    end
    if (sb.errors == 0 && sb.awaited.size() == 0) begin
      $display("variable_record_byte_stack: match");
    end else begin
      $display("variable_record_byte_stack: mismatch");
    end
    $finish;
  end

endmodule

FILE: filelist.f
rtl/vrbs_pkg.sv
rtl/vrbs_if.sv
rtl/vrbs_ctrl.sv
rtl/vrbs_dpath.sv
rtl/variable_record_byte_stack.sv
test/tb.sv
